// ===== rtl/mst_edge_insert_update_assert.svh =====
// Assertion macros for the edge insert / update block.
`ifndef MST_EDGE_INSERT_UPDATE_ASSERT_SVH
`define MST_EDGE_INSERT_UPDATE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MEIU_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define MEIU_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/meiu_pkg.sv =====
// ---------------------------------------------------------------------------
// meiu_pkg
// Types and constants shared by the edge insert / update block.
// ---------------------------------------------------------------------------
package meiu_pkg;
  localparam int MaxNodes  = 8;
  localparam int EdgeSlots = MaxNodes * (MaxNodes - 1) / 2;
  localparam int SlotW     = $clog2(EdgeSlots);
  localparam int CntW      = $clog2(EdgeSlots + 1);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  localparam logic [2:0] ST_LOADED  = 3'd0;
  localparam logic [2:0] ST_IGNORED = 3'd1;
  localparam logic [2:0] ST_LOWERED = 3'd2;
  localparam logic [2:0] ST_REBUILT = 3'd3;
  localparam logic [2:0] ST_ENTRY   = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  node_a;
    logic [2:0]  node_b;
    logic [15:0] weight;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  edge_low;
    logic [2:0]  edge_high;
    logic [15:0] edge_weight;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  lo;
    logic [2:0]  hi;
    logic [15:0] w;
  } sedge_t;

  function automatic logic [SlotW-1:0] slot_of(input logic [2:0] lo, input logic [2:0] hi);
    logic [7:0] l, h, s;
    l = {5'd0, lo};
    h = {5'd0, hi};
    s = l * 8'(MaxNodes) - ((l * (l + 8'd1)) >> 1) + (h - l - 8'd1);
    return s[SlotW-1:0];
  endfunction
endpackage

// ===== rtl/meiu_ram.sv =====
// ---------------------------------------------------------------------------
// meiu_ram
// Generic single-port-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module meiu_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/mst_edge_insert_update.sv =====
// ---------------------------------------------------------------------------
// mst_edge_insert_update
// Edge table keeper with Kruskal rebuild on insert, and sorted listing.
// ---------------------------------------------------------------------------
// Commands enter on start while busy is low; every command holds busy until
// its last result word has been strobed out on out_valid, and results cannot
// be held off. Load and most ignored cases go from decode straight to the
// result word. List and a tree rebuild run a sequencer over the upper
// triangle of pair slots; the insertion sort is shared and reads, then
// compares and shifts, one stored entry at a time. A list adds one read,
// wait and output step per stored edge; a rebuild adds one max scan, a read,
// wait and check step per sorted edge, a relabel pass over the active nodes
// per kept edge, a clear state and a write-back read, wait and put per edge.
// Edge weights live in flip-flops with reset to zero (28 entries); the
// sorted list sits in a RAM, component labels in a small register file.
// node_count is to be taken from cfg_wdata only while idle, a rule on the
// user that the block itself does not enforce; out-of-range values clamp.
module mst_edge_insert_update (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  meiu_pkg::in_word_t   in_word,
  output logic                 out_valid,
  output meiu_pkg::out_word_t  out_word,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_wdata
);
  import meiu_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_MAXSCAN, S_SORT_SCAN, S_SORT_RD, S_SORT_CMP, S_SORT_PUT,
    S_LAB_INIT, S_K_RD, S_K_WAIT, S_K_CHK, S_K_RELAB, S_CLEAR, S_WB_RD, S_WB_WAIT,
    S_WB_PUT, S_LIST_RD, S_LIST_WAIT, S_LIST_OUT, S_DONE
  } state_t;

  state_t              state_r;
  logic [3:0]          ncfg_r;
  in_word_t            cmd_r;
  logic [15:0]         wt_r [EdgeSlots];
  logic [2:0]          lab_r [MaxNodes];
  logic [EdgeSlots-1:0] keep_r;
  logic [2:0]          i_r, j_r;
  logic [CntW-1:0]     cnt_r, p_r, k_r;
  logic [15:0]         top_r;
  logic [2:0]          la_r, lb_r;
  logic                is_list_r, joined_r;
  logic [2:0]          rs_r;
  out_word_t           out_r;
  logic                ov_r;

  // sorted-edge RAM
  logic                ram_we;
  logic [SlotW-1:0]    ram_wa, ram_ra;
  sedge_t              ram_wd, ram_rd, hold_r;

  meiu_ram #(.Width($bits(sedge_t)), .Depth(EdgeSlots)) u_sorted (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd), .raddr(ram_ra),
    .rdata(ram_rd)
  );

  logic [2:0] n_m1;
  always_comb begin
    priority if (ncfg_r < 4'd2) n_m1 = 3'd1;
    else if (ncfg_r > 4'(MaxNodes)) n_m1 = 3'(MaxNodes - 1);
    else n_m1 = 3'(ncfg_r - 4'd1);
  end

  logic [2:0] lo_c, hi_c;
  assign lo_c = (cmd_r.node_a < cmd_r.node_b) ? cmd_r.node_a : cmd_r.node_b;
  assign hi_c = (cmd_r.node_a < cmd_r.node_b) ? cmd_r.node_b : cmd_r.node_a;

  logic [15:0] w_ij;
  assign w_ij = wt_r[slot_of(i_r, j_r)];

  // all nodes in use share label 0's component
  logic all_join;
  always_comb begin
    all_join = 1'b1;
    for (int q = 1; q < MaxNodes; q++) begin
      if (3'(q) <= n_m1 && lab_r[q] != lab_r[0]) all_join = 1'b0;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_word  = out_r;

  // hold the read address through the wait cycle so the data stays put
  always_comb begin
    ram_we = 1'b0;
    ram_wa = p_r[SlotW-1:0];
    ram_wd = hold_r;
    ram_ra = p_r[SlotW-1:0];
    unique case (state_r)
      S_SORT_SCAN: ram_ra = SlotW'(p_r - CntW'(1));
      S_SORT_RD:   ram_ra = SlotW'(p_r - CntW'(1));
      S_SORT_CMP: begin
        ram_we = (p_r != '0) && (ram_rd.w > hold_r.w);
        ram_wd = ram_rd;
      end
      S_SORT_PUT:  ram_we = 1'b1;
      S_K_RD, S_WB_RD, S_WB_WAIT, S_LIST_RD, S_LIST_WAIT: ram_ra = k_r[SlotW-1:0];
      default: ;
    endcase
  end

  // step over the upper triangle (i<j<=n_m1); advance j then i
  logic       tri_last;
  logic [2:0] ni, nj;
  always_comb begin
    tri_last = (i_r == n_m1 - 3'd1) && (j_r == n_m1);
    if (j_r == n_m1) begin
      ni = i_r + 3'd1;
      nj = i_r + 3'd2;
    end else begin
      ni = i_r;
      nj = j_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ncfg_r  <= 4'd8;
      ov_r    <= 1'b0;
      for (int q = 0; q < EdgeSlots; q++) wt_r[q] <= '0;
    end else begin
      ov_r <= 1'b0;
      if (cfg_we) ncfg_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r   <= in_word;
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          i_r <= '0;
          j_r <= 3'd1;
          cnt_r <= '0;
          top_r <= '0;
          rs_r  <= ST_IGNORED;
          is_list_r <= 1'b0;
          priority if (cmd_r.op == OP_LIST) begin
            is_list_r <= 1'b1;
            state_r   <= S_SORT_SCAN;
            p_r       <= '0;
          end else if (!(cmd_r.op == OP_LOAD || cmd_r.op == OP_INSERT) ||
                       cmd_r.node_a == cmd_r.node_b ||
                       cmd_r.node_a > n_m1 || cmd_r.node_b > n_m1) begin
            state_r <= S_DONE;
          end else if (cmd_r.op == OP_LOAD) begin
            wt_r[slot_of(lo_c, hi_c)] <= cmd_r.weight;
            rs_r    <= ST_LOADED;
            state_r <= S_DONE;
          end else if (wt_r[slot_of(lo_c, hi_c)] != '0) begin
            if (cmd_r.weight < wt_r[slot_of(lo_c, hi_c)]) begin
              wt_r[slot_of(lo_c, hi_c)] <= cmd_r.weight;
              rs_r <= ST_LOWERED;
            end
            state_r <= S_DONE;
          end else begin
            state_r <= S_MAXSCAN;
          end
        end
        S_MAXSCAN: begin
          if (w_ij > top_r) top_r <= w_ij;
          i_r <= ni;
          j_r <= nj;
          if (tri_last) begin
            i_r <= '0;
            j_r <= 3'd1;
            if (cmd_r.weight >= ((w_ij > top_r) ? w_ij : top_r)) begin
              state_r <= S_DONE;
            end else begin
              wt_r[slot_of(lo_c, hi_c)] <= cmd_r.weight;
              state_r <= S_SORT_SCAN;
            end
          end
        end
        // scan one slot; a nonzero weight starts an insertion at the tail
        S_SORT_SCAN: begin
          if (w_ij != '0) begin
            hold_r  <= '{lo: i_r, hi: j_r, w: w_ij};
            p_r     <= cnt_r;
            state_r <= S_SORT_RD;
          end else if (tri_last) begin
            state_r <= is_list_r ? S_LIST_RD : S_LAB_INIT;
            k_r <= '0;
          end else begin
            i_r <= ni;
            j_r <= nj;
          end
        end
        S_SORT_RD: state_r <= (p_r == '0) ? S_SORT_PUT : S_SORT_CMP;
        S_SORT_CMP: begin
          if (ram_rd.w > hold_r.w) begin
            p_r     <= p_r - CntW'(1);
            state_r <= (p_r == CntW'(1)) ? S_SORT_PUT : S_SORT_RD;
          end else begin
            state_r <= S_SORT_PUT;
          end
        end
        S_SORT_PUT: begin
          cnt_r <= cnt_r + CntW'(1);
          if (tri_last) begin
            state_r <= is_list_r ? S_LIST_RD : S_LAB_INIT;
            k_r <= '0;
          end else begin
            i_r <= ni;
            j_r <= nj;
            state_r <= S_SORT_SCAN;
          end
        end
        S_LAB_INIT: begin
          for (int q = 0; q < MaxNodes; q++) lab_r[q] <= 3'(q);
          keep_r  <= '0;
          k_r     <= '0;
          state_r <= (cnt_r == '0) ? S_CLEAR : S_K_RD;
        end
        S_K_RD: state_r <= S_K_WAIT;
        S_K_WAIT: begin
          hold_r   <= ram_rd;
          joined_r <= all_join;
          state_r  <= S_K_CHK;
        end
        S_K_CHK: begin
          la_r <= lab_r[hold_r.lo];
          lb_r <= lab_r[hold_r.hi];
          if (joined_r || lab_r[hold_r.lo] == lab_r[hold_r.hi]) begin
            k_r <= k_r + CntW'(1);
            state_r <= (k_r + CntW'(1) == cnt_r) ? S_CLEAR : S_K_RD;
          end else begin
            keep_r[k_r[SlotW-1:0]] <= 1'b1;
            i_r <= '0;
            state_r <= S_K_RELAB;
          end
        end
        // relabel one node a cycle: merge component la into lb
        S_K_RELAB: begin
          if (lab_r[i_r] == la_r) lab_r[i_r] <= lb_r;
          i_r <= i_r + 3'd1;
          if (i_r == n_m1) begin
            k_r <= k_r + CntW'(1);
            state_r <= (k_r + CntW'(1) == cnt_r) ? S_CLEAR : S_K_RD;
          end
        end
        S_CLEAR: begin
          for (int a = 0; a < MaxNodes; a++) begin
            for (int b = a + 1; b < MaxNodes; b++) begin
              if (3'(b) <= n_m1) wt_r[slot_of(3'(a), 3'(b))] <= '0;
            end
          end
          k_r <= '0;
          rs_r <= ST_REBUILT;
          state_r <= (cnt_r == '0) ? S_DONE : S_WB_RD;
        end
        S_WB_RD: state_r <= S_WB_WAIT;
        S_WB_WAIT: state_r <= S_WB_PUT;
        S_WB_PUT: begin
          if (keep_r[k_r[SlotW-1:0]]) wt_r[slot_of(ram_rd.lo, ram_rd.hi)] <= ram_rd.w;
          k_r <= k_r + CntW'(1);
          state_r <= (k_r + CntW'(1) == cnt_r) ? S_DONE : S_WB_RD;
        end
        S_LIST_RD: begin
          if (cnt_r == '0) begin
            rs_r <= ST_EMPTY;
            state_r <= S_DONE;
          end else begin
            state_r <= S_LIST_WAIT;
          end
        end
        S_LIST_WAIT: state_r <= S_LIST_OUT;
        S_LIST_OUT: begin
          ov_r  <= 1'b1;
          out_r <= '{status: ST_ENTRY, edge_low: ram_rd.lo, edge_high: ram_rd.hi,
                     edge_weight: ram_rd.w, last: (k_r + CntW'(1) == cnt_r)};
          k_r <= k_r + CntW'(1);
          state_r <= (k_r + CntW'(1) == cnt_r) ? S_IDLE : S_LIST_RD;
        end
        S_DONE: begin
          ov_r  <= 1'b1;
          out_r <= '{status: rs_r, edge_low: '0, edge_high: '0, edge_weight: '0,
                     last: 1'b1};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/meiu_checker.sv =====
// ---------------------------------------------------------------------------
// meiu_checker
// Port-level checks on the edge insert / update block.
// ---------------------------------------------------------------------------
`include "mst_edge_insert_update_assert.svh"
module meiu_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input meiu_pkg::out_word_t out_word
);
  import meiu_pkg::*;
  `MEIU_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `MEIU_ASSERT_IMPL(a_out_when_busy, clk, rst_n, out_valid && !out_word.last, busy)
  `MEIU_ASSERT_IMPL(a_nonlist_last, clk, rst_n, out_valid && out_word.status != ST_ENTRY, out_word.last)
  `MEIU_ASSERT_NEXT(a_last_frees, clk, rst_n, out_valid && out_word.last, !out_valid)
endmodule

bind mst_edge_insert_update meiu_checker u_meiu_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_word(out_word)
);

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the edge table / spanning tree keeper: random and
// directed command words, a local model of the table, in-order word check.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import meiu_pkg::*;

  localparam int LIMIT = 3_000_000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;
  logic      cfg_we = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;

  mst_edge_insert_update uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state: the weight table and the node count register.
  logic [15:0] table_w [EdgeSlots];
  logic [3:0]  nodes_reg;

  in_word_t  cmd_q [$];
  out_word_t expected_words [$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 31;
  bit hold_send = 1'b0;
  logic busy_at_rise = 1'b1;

  function automatic int pair_slot(int lo, int hi);
    return lo * MaxNodes - lo * (lo + 1) / 2 + (hi - lo - 1);
  endfunction

  function automatic int active_nodes();
    int n;
    n = nodes_reg;
    if (n < 2) n = 2;
    if (n > MaxNodes) n = MaxNodes;
    return n;
  endfunction

  function automatic out_word_t mk(logic [2:0] st, int lo, int hi, int w, bit lst);
    out_word_t o;
    o.status = st;
    o.edge_low = lo[2:0];
    o.edge_high = hi[2:0];
    o.edge_weight = w[15:0];
    o.last = lst;
    return o;
  endfunction

  // Stable sort of stored edges by weight, ties in row-major order.
  task automatic sort_edges(input int n, output sedge_t se [$]);
    sedge_t e;
    int p;
    se = {};
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++) begin
        if (table_w[pair_slot(i, j)] == 0) continue;
        e.lo = i[2:0];
        e.hi = j[2:0];
        e.w = table_w[pair_slot(i, j)];
        p = se.size();
        while (p > 0 && se[p-1].w > e.w) p--;
        se.insert(p, e);
      end
  endtask

  task automatic kruskal_rebuild(input int n);
    sedge_t se [$];
    logic [2:0] lbl [MaxNodes];
    bit keep [$];
    bit joined;
    logic [2:0] la, lb;
    sort_edges(n, se);
    for (int i = 0; i < n; i++) lbl[i] = i[2:0];
    foreach (se[k]) begin
      keep.push_back(1'b0);
      joined = 1'b1;
      for (int i = 1; i < n; i++) if (lbl[i] != lbl[0]) joined = 1'b0;
      if (joined) continue;
      la = lbl[se[k].lo];
      lb = lbl[se[k].hi];
      if (la == lb) continue;
      keep[k] = 1'b1;
      for (int j = 0; j < n; j++) if (lbl[j] == la) lbl[j] = lb;
    end
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++) table_w[pair_slot(i, j)] = 16'd0;
    foreach (se[k]) if (keep[k]) table_w[pair_slot(se[k].lo, se[k].hi)] = se[k].w;
  endtask

  // Work out the result words of one accepted command word.
  task automatic predict_tree_update(input in_word_t c);
    int n, lo, hi, s;
    logic [15:0] top;
    sedge_t se [$];
    n = active_nodes();
    lo = (c.node_a < c.node_b) ? c.node_a : c.node_b;
    hi = (c.node_a < c.node_b) ? c.node_b : c.node_a;
    if (c.op == OP_LIST) begin
      sort_edges(n, se);
      if (se.size() == 0) expected_words.push_back(mk(ST_EMPTY, 0, 0, 0, 1'b1));
      foreach (se[k])
        expected_words.push_back(mk(ST_ENTRY, se[k].lo, se[k].hi, se[k].w,
                                    k == se.size() - 1));
      return;
    end
    if (!(c.op inside {OP_LOAD, OP_INSERT}) || lo == hi || hi >= n) begin
      expected_words.push_back(mk(ST_IGNORED, 0, 0, 0, 1'b1));
      return;
    end
    s = pair_slot(lo, hi);
    if (c.op == OP_LOAD) begin
      table_w[s] = c.weight;
      expected_words.push_back(mk(ST_LOADED, 0, 0, 0, 1'b1));
      return;
    end
    if (table_w[s] != 0) begin
      if (c.weight >= table_w[s]) begin
        expected_words.push_back(mk(ST_IGNORED, 0, 0, 0, 1'b1));
      end else begin
        table_w[s] = c.weight;
        expected_words.push_back(mk(ST_LOWERED, 0, 0, 0, 1'b1));
      end
      return;
    end
    top = 16'd0;
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++)
        if (table_w[pair_slot(i, j)] > top) top = table_w[pair_slot(i, j)];
    if (c.weight >= top) begin
      expected_words.push_back(mk(ST_IGNORED, 0, 0, 0, 1'b1));
      return;
    end
    table_w[s] = c.weight;
    kruskal_rebuild(n);
    expected_words.push_back(mk(ST_REBUILT, 0, 0, 0, 1'b1));
  endtask

  task automatic report_mismatch(input string what, input out_word_t got,
                                 input out_word_t want);
    errors++;
    $display("MISMATCH %s: got st=%0d %0d-%0d w=%0d last=%0d want st=%0d %0d-%0d w=%0d last=%0d",
             what, got.status, got.edge_low, got.edge_high, got.edge_weight, got.last,
             want.status, want.edge_low, want.edge_high, want.edge_weight, want.last);
  endtask

  // Driver: present the next word at the falling edge; advance on acceptance.
  always @(negedge clk) begin
    if (rst_n && start && !busy_at_rise) void'(cmd_q.pop_front());
    if (rst_n && cmd_q.size() > 0 && !hold_send &&
        $urandom_range(99, 0) >= idle_pct) begin
      start <= 1'b1;
      in_word <= cmd_q[0];
    end else begin
      start <= 1'b0;
      in_word <= in_word_t'($urandom);
    end
  end

  // Sample busy and start at the rising edge to decide acceptance.
  always @(posedge clk) begin
    cycles++;
    busy_at_rise <= busy;
    if (rst_n && start && !busy) predict_tree_update(in_word);
    if (cfg_we) nodes_reg = cfg_wdata;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** mst_edge_insert_update: FAILED **");
      $finish;
    end
  end

  // Monitor: every strobed word must match the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_word, '0);
      end else begin
        if (out_word !== expected_words[0])
          report_mismatch("field", out_word, expected_words[0]);
        void'(expected_words.pop_front());
      end
    end
  end

  function automatic in_word_t rand_cmd(int n, bit valid_only);
    in_word_t c;
    c = in_word_t'($urandom);
    if (valid_only) begin
      c.op = ($urandom_range(9, 0) < 6) ? OP_INSERT : OP_LOAD;
      c.node_a = 3'($urandom_range(n - 1, 0));
      c.node_b = 3'($urandom_range(n - 1, 0));
    end
    case ($urandom_range(3, 0))
      0: c.weight = 16'($urandom_range(40, 0));
      1: c.weight = 16'($urandom_range(400, 1));
      default: ;
    endcase
    return c;
  endfunction

  function automatic in_word_t cmd(logic [1:0] op, int a, int b, int w);
    in_word_t c;
    c.op = op;
    c.node_a = a[2:0];
    c.node_b = b[2:0];
    c.weight = w[15:0];
    return c;
  endfunction

  task automatic drain();
    wait (cmd_q.size() == 0 && expected_words.size() == 0);
    // Ignored commands produce a word early; let the sequencer settle.
    repeat (1000) @(posedge clk);
  endtask

  task automatic set_nodes(input logic [3:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= 4'($urandom);
  endtask

  initial begin
    logic [3:0] cfg_vals [6] = '{4'd0, 4'd2, 4'd15, 4'd5, 4'd8, 4'd3};
    int n;
    foreach (table_w[i]) table_w[i] = 16'd0;
    nodes_reg = 4'd8;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, loads, lowering, rebuild, edge cases.
    cmd_q.push_back(cmd(OP_LIST, 0, 0, 0));
    cmd_q.push_back(cmd(OP_INSERT, 0, 1, 5));
    cmd_q.push_back(cmd(OP_LOAD, 0, 1, 65535));
    cmd_q.push_back(cmd(OP_LOAD, 7, 6, 100));
    cmd_q.push_back(cmd(OP_LOAD, 1, 2, 100));
    cmd_q.push_back(cmd(OP_LOAD, 0, 2, 50));
    cmd_q.push_back(cmd(OP_LOAD, 3, 3, 9));
    cmd_q.push_back(cmd(2'd3, 1, 4, 9));
    cmd_q.push_back(cmd(OP_INSERT, 1, 2, 200));
    cmd_q.push_back(cmd(OP_INSERT, 2, 1, 60));
    cmd_q.push_back(cmd(OP_INSERT, 3, 4, 65535));
    cmd_q.push_back(cmd(OP_INSERT, 3, 4, 0));
    cmd_q.push_back(cmd(OP_INSERT, 0, 3, 1));
    cmd_q.push_back(cmd(OP_LIST, 5, 5, 0));
    cmd_q.push_back(cmd(OP_INSERT, 0, 2, 0));
    cmd_q.push_back(cmd(OP_LOAD, 0, 1, 0));
    cmd_q.push_back(cmd(OP_LIST, 7, 0, 65535));
    drain();

    // Random phases over several node counts; the first runs with no idling.
    foreach (cfg_vals[p]) begin
      set_nodes(cfg_vals[p]);
      n = (cfg_vals[p] < 2) ? 2 : (cfg_vals[p] > 8 ? 8 : cfg_vals[p]);
      idle_pct = (p == 0) ? 0 : 31;
      for (int i = 0; i < 65; i++) begin
        if ($urandom_range(9, 0) == 0) cmd_q.push_back(cmd(OP_LIST, 0, 0, 0));
        else cmd_q.push_back(rand_cmd(n, $urandom_range(9, 0) < 8));
        if (i == 30) begin
          // Hold the sender until every result so far has come.
          wait (cmd_q.size() == 0);
          hold_send = 1'b1;
          wait (expected_words.size() == 0);
          hold_send = 1'b0;
        end
      end
      cmd_q.push_back(cmd(OP_LIST, 0, 0, 0));
      drain();
    end

    if (errors == 0) begin
      $display("** mst_edge_insert_update: PASSED **");
    end else begin
      $display("** mst_edge_insert_update: FAILED **");
    end
    $finish;
  end
endmodule
